[hdl/rv32_pkg.sv]
// Shared types and constants for the RV32IM executor.
package rv32_pkg;

  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_EBREAK  = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Shared ALU operations.
  localparam logic [3:0] ALU_ADD  = 4'd0;
  localparam logic [3:0] ALU_SUB  = 4'd1;
  localparam logic [3:0] ALU_SLL  = 4'd2;
  localparam logic [3:0] ALU_SLT  = 4'd3;
  localparam logic [3:0] ALU_SLTU = 4'd4;
  localparam logic [3:0] ALU_XOR  = 4'd5;
  localparam logic [3:0] ALU_SRL  = 4'd6;
  localparam logic [3:0] ALU_SRA  = 4'd7;
  localparam logic [3:0] ALU_OR   = 4'd8;
  localparam logic [3:0] ALU_AND  = 4'd9;
  localparam logic [3:0] ALU_MUL  = 4'd10;
  localparam logic [3:0] ALU_MULH = 4'd11;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [3:0]  op;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        eq;
    logic        lt;
    logic        ltu;
  } alu_rsp_t;

  typedef struct packed {
    logic        start;
    logic        is_signed;
    logic        want_rem;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  function automatic logic [31:0] sext_n(input logic [31:0] v, input int unsigned bits);
    logic [31:0] m;
    logic [31:0] r;
    m = (32'd1 << bits) - 32'd1;
    r = v & m;
    if (r[bits-1]) r = r | ~m;
    return r;
  endfunction

endpackage

[hdl/rv32_alu.sv]
// Shared ALU: add, compare, shift, logic and one 33x33 multiply.
module rv32_alu import rv32_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod;

  always_comb begin
    ma = (req.op == ALU_MULH) ? {req.a[31], req.a} : {1'b0, req.a};
    mb = (req.op == ALU_MULH) ? {req.b[31], req.b} : {1'b0, req.b};
    prod = ma * mb;
    rsp.eq  = (req.a == req.b);
    rsp.ltu = (req.a < req.b);
    rsp.lt  = ($signed(req.a) < $signed(req.b));
    unique case (req.op)
      ALU_ADD:  rsp.res = req.a + req.b;
      ALU_SUB:  rsp.res = req.a - req.b;
      ALU_SLL:  rsp.res = req.a << req.b[4:0];
      ALU_SLT:  rsp.res = {31'd0, rsp.lt};
      ALU_SLTU: rsp.res = {31'd0, rsp.ltu};
      ALU_XOR:  rsp.res = req.a ^ req.b;
      ALU_SRL:  rsp.res = req.a >> req.b[4:0];
      ALU_SRA:  rsp.res = 32'($signed(req.a) >>> req.b[4:0]);
      ALU_OR:   rsp.res = req.a | req.b;
      ALU_AND:  rsp.res = req.a & req.b;
      ALU_MUL:  rsp.res = prod[31:0];
      ALU_MULH: rsp.res = prod[63:32];
      default:  rsp.res = '0;
    endcase
  end
endmodule

[hdl/rv32_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module rv32_div import rv32_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [31:0] result
);
  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r, d_nxt;
  logic        negq_r, negq_nxt, negr_r, negr_nxt, wrem_r, wrem_nxt;
  logic        spec_r, spec_nxt;
  logic [31:0] sres_r, sres_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [31:0] ma, mb;

  always_comb begin
    busy_nxt = busy_r; cnt_nxt = cnt_r; q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r;
    negq_nxt = negq_r; negr_nxt = negr_r; wrem_nxt = wrem_r; spec_nxt = spec_r;
    sres_nxt = sres_r; done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[31]} - {1'b0, d_r};
    ma = (req.is_signed && req.a[31]) ? 32'd0 - req.a : req.a;
    mb = (req.is_signed && req.b[31]) ? 32'd0 - req.b : req.b;
    if (req.start) begin
      busy_nxt = 1'b1; cnt_nxt = 6'd32; q_nxt = ma; rem_nxt = '0; d_nxt = mb;
      negq_nxt = req.is_signed && (req.a[31] ^ req.b[31]);
      negr_nxt = req.is_signed && req.a[31];
      wrem_nxt = req.want_rem;
      spec_nxt = 1'b0; sres_nxt = '0;
      if (req.b == 32'd0) begin
        spec_nxt = 1'b1; sres_nxt = req.want_rem ? req.a : 32'hFFFF_FFFF;
      end else if (req.is_signed && req.a == 32'h8000_0000 && req.b == 32'hFFFF_FFFF) begin
        spec_nxt = 1'b1; sres_nxt = req.want_rem ? 32'd0 : req.a;
      end
    end else if (busy_r) begin
      if (cnt_r == 6'd0 || spec_r) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end else begin
        // shift in one dividend bit, subtract if it fits
        if (!trial[32]) begin
          rem_nxt = trial;
          q_nxt = {q_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], q_r[31]};
          q_nxt = {q_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt; q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
    negq_r <= negq_nxt; negr_r <= negr_nxt; wrem_r <= wrem_nxt;
    spec_r <= spec_nxt; sres_r <= sres_nxt;
  end

  assign done = done_r;
  always_comb begin
    if (spec_r) result = sres_r;
    else if (wrem_r) result = negr_r ? 32'd0 - rem_r[31:0] : rem_r[31:0];
    else result = negq_r ? 32'd0 - q_r : q_r;
  end
endmodule

[hdl/rv32im_instruction_executor.sv]
// Top level: sequencer, register file and load tracking for the RV32IM executor.
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction: in_opcode 0
//   executes in_instruction at in_pc, in_opcode 1 hands in_load_data to the
//   load that is parked. The result channel (out_valid/out_ready) returns one
//   transaction per input: next pc, memory request, status and trap value.
//   A load issues its request and parks rd, size and signedness; the next
//   load-data transaction writes the extended data to that register.
// Sequencing:
//   Most instructions pass through decode and register read, execute on the
//   shared ALU and writeback before out_valid rises. div/divu/rem/remu also
//   wait for the divider, which produces one quotient bit per cycle; division
//   by zero and signed overflow skip its iterations. in_ready is low while an
//   item is in flight or its result waits.
// Reset: rst_n low clears the register file, pending load and handshakes.
// Stall: when out_ready is low the result holds in the output register and
//   no new transaction is accepted until it is taken.
module rv32im_instruction_executor import rv32_pkg::*; #(
  parameter int REGISTER_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_pc,
  input  logic [31:0] in_load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_pc,
  output logic        out_mem_valid,
  output logic        out_mem_write,
  output logic [31:0] out_mem_addr,
  output logic [1:0]  out_mem_size,
  output logic [31:0] out_mem_wdata,
  output logic [1:0]  out_status,
  output logic [31:0] out_trap_value
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_EXE  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic        opc_r;
  logic [31:0] ins_r, pc_r, ld_r;
  logic [31:0] rf_r [REGISTER_COUNT];
  logic [31:0] a_r, b_r, tval_r;
  logic [31:0] res_r, res_nxt;
  logic        pend_r, pend_nxt;
  logic [4:0]  pdest_r, pdest_nxt;
  logic [1:0]  psize_r, psize_nxt;
  logic        psgn_r, psgn_nxt;

  logic [31:0] o_npc_r, o_npc_nxt, o_addr_r, o_addr_nxt, o_wdata_r, o_wdata_nxt;
  logic [31:0] o_tval_r, o_tval_nxt;
  logic        o_mv_r, o_mv_nxt, o_mw_r, o_mw_nxt;
  logic [1:0]  o_size_r, o_size_nxt, o_st_r, o_st_nxt;

  logic        we;
  logic [4:0]  wa;
  logic [31:0] wd;

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd, rs1, rs2;
  logic [31:0] immi, imms, immb, immj, immu;
  alu_req_t    areq;
  alu_rsp_t    arsp;
  div_req_t    dreq;
  logic        ddone;
  logic [31:0] dres;
  logic        is_div;
  logic        taken;
  logic        legal_wr; // instruction writes rd
  logic [31:0] ldx;

  assign op  = ins_r[6:0];
  assign f3  = ins_r[14:12];
  assign f7  = ins_r[31:25];
  assign rd  = ins_r[11:7];
  assign rs1 = ins_r[19:15];
  assign rs2 = ins_r[24:20];
  assign immi = sext_n({20'd0, ins_r[31:20]}, 12);
  assign imms = sext_n({20'd0, ins_r[31:25], ins_r[11:7]}, 12);
  assign immb = sext_n({19'd0, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0}, 13);
  assign immj = sext_n({11'd0, ins_r[31], ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0}, 21);
  assign immu = {ins_r[31:12], 12'd0};

  function automatic logic [31:0] rf_rd(input logic [4:0] idx, input logic [31:0] v);
    return (idx == 5'd0 || 32'(idx) >= REGISTER_COUNT) ? 32'd0 : v;
  endfunction

  logic [31:0] rf_a, rf_b, rf_t;
  always_comb begin
    rf_a = '0; rf_b = '0; rf_t = '0;
    for (int i = 0; i < REGISTER_COUNT; i++) begin
      if (32'(rs1) == i) rf_a = rf_r[i];
      if (32'(rs2) == i) rf_b = rf_r[i];
      if (i == 10) rf_t = rf_r[i];
    end
  end

  assign is_div = (op == OP_REG) && (f7 == 7'd1) && f3[2];

  // ALU operand and operation selection during execute
  always_comb begin
    areq.a = a_r; areq.b = b_r; areq.op = ALU_ADD;
    priority if (op == OP_LUI) begin
      areq.a = 32'd0; areq.b = immu;
    end else if (op == OP_AUIPC) begin
      areq.a = pc_r; areq.b = immu;
    end else if (op == OP_JAL || op == OP_JALR) begin
      areq.a = pc_r; areq.b = 32'd4;
    end else if (op == OP_LOAD || op == OP_JALR) begin
      areq.b = immi;
    end else if (op == OP_STORE) begin
      areq.b = imms;
    end else if (op == OP_REG && f7 == 7'd1) begin
      areq.op = (f3 == 3'd1) ? ALU_MULH : ALU_MUL;
    end else if (op == OP_REG || op == OP_IMM) begin
      if (op == OP_IMM) areq.b = (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, ins_r[24:20]} : immi;
      unique case (f3)
        3'd0: areq.op = (op == OP_REG && f7[5]) ? ALU_SUB : ALU_ADD;
        3'd1: areq.op = ALU_SLL;
        3'd2: areq.op = ALU_SLT;
        3'd3: areq.op = ALU_SLTU;
        3'd4: areq.op = ALU_XOR;
        3'd5: areq.op = f7[5] ? ALU_SRA : ALU_SRL;
        3'd6: areq.op = ALU_OR;
        default: areq.op = ALU_AND;
      endcase
    end
  end

  rv32_alu u_alu (.req(areq), .rsp(arsp));

  assign dreq.start     = (state_r == S_EXE) && is_div && !opc_r;
  assign dreq.is_signed = !f3[0];
  assign dreq.want_rem  = f3[1];
  assign dreq.a         = a_r;
  assign dreq.b         = b_r;
  rv32_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .result(dres));

  always_comb begin
    unique case (f3)
      3'd0: taken = arsp.eq;
      3'd1: taken = !arsp.eq;
      3'd4: taken = arsp.lt;
      3'd5: taken = !arsp.lt;
      3'd6: taken = arsp.ltu;
      default: taken = !arsp.ltu;
    endcase
  end

  always_comb begin
    unique case (psize_r)
      SZ_BYTE: ldx = psgn_r ? sext_n({24'd0, ld_r[7:0]}, 8) : {24'd0, ld_r[7:0]};
      SZ_HALF: ldx = psgn_r ? sext_n({16'd0, ld_r[15:0]}, 16) : {16'd0, ld_r[15:0]};
      default: ldx = ld_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt = res_r;
    pend_nxt = pend_r; pdest_nxt = pdest_r; psize_nxt = psize_r; psgn_nxt = psgn_r;
    o_npc_nxt = o_npc_r; o_mv_nxt = o_mv_r; o_mw_nxt = o_mw_r; o_addr_nxt = o_addr_r;
    o_size_nxt = o_size_r; o_wdata_nxt = o_wdata_r; o_st_nxt = o_st_r; o_tval_nxt = o_tval_r;
    legal_wr = 1'b0;
    we = 1'b0; wa = rd; wd = res_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DEC;
      S_DEC:  state_nxt = S_EXE;
      S_EXE: begin
        o_npc_nxt = pc_r + 32'd4; o_mv_nxt = 1'b0; o_mw_nxt = 1'b0; o_addr_nxt = '0;
        o_size_nxt = SZ_BYTE; o_wdata_nxt = '0; o_st_nxt = ST_NORMAL; o_tval_nxt = '0;
        res_nxt = arsp.res;
        state_nxt = S_WB;
        if (opc_r) begin
          o_npc_nxt = '0;
        end else if (op == OP_LUI || op == OP_AUIPC || op == OP_JAL) begin
          if (op == OP_JAL) o_npc_nxt = pc_r + immj;
        end else if (op == OP_JALR && f3 == 3'd0) begin
          o_npc_nxt = (a_r + immi) & ~32'd1;
        end else if (op == OP_BRANCH && f3[2:1] != 2'b01) begin
          if (taken) o_npc_nxt = pc_r + immb;
        end else if (op == OP_LOAD && f3[1:0] != 2'd3 && f3[2:1] != 2'b11) begin
          o_mv_nxt = 1'b1; o_addr_nxt = arsp.res; o_size_nxt = f3[1:0];
          pend_nxt = 1'b1; pdest_nxt = rd; psize_nxt = f3[1:0]; psgn_nxt = !f3[2];
        end else if (op == OP_STORE && f3 < 3'd3) begin
          o_mv_nxt = 1'b1; o_mw_nxt = 1'b1; o_addr_nxt = arsp.res; o_size_nxt = f3[1:0];
          o_wdata_nxt = (f3 == 3'd0) ? {24'd0, b_r[7:0]} :
                        (f3 == 3'd1) ? {16'd0, b_r[15:0]} : b_r;
        end else if (op == OP_REG && (f7 == 7'd0 ||
                     (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)) ||
                     (f7 == 7'd1 && f3[2:1] != 2'b01))) begin
          if (is_div) state_nxt = S_DIV;
        end else if (op == OP_IMM && (f3[1:0] != 2'd1 || (f3 == 3'd1 && f7 == 7'd0) ||
                     (f3 == 3'd5 && (f7 == 7'd0 || f7 == 7'h20)))) begin
          res_nxt = arsp.res;
        end else if (ins_r == WORD_EBREAK) begin
          o_st_nxt = ST_EBREAK; o_tval_nxt = tval_r;
        end else begin
          o_st_nxt = ST_ILLEGAL;
        end
      end
      S_DIV: if (ddone) begin
        res_nxt = dres; state_nxt = S_WB;
      end
      S_WB: begin
        state_nxt = S_OUT;
        if (opc_r) begin
          if (pend_r) begin
            we = 1'b1; wa = pdest_r; wd = ldx; pend_nxt = 1'b0;
          end
        end else begin
          legal_wr = (o_st_r == ST_NORMAL) && op != OP_BRANCH && op != OP_LOAD &&
                     op != OP_STORE;
          we = legal_wr;
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r <= 1'b0; pdest_r <= '0; psize_r <= '0; psgn_r <= 1'b0;
      for (int i = 0; i < REGISTER_COUNT; i++) rf_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r <= pend_nxt; pdest_r <= pdest_nxt; psize_r <= psize_nxt; psgn_r <= psgn_nxt;
      if (we && wa != 5'd0 && 32'(wa) < REGISTER_COUNT) rf_r[wa] <= wd;
    end
    if (state_r == S_IDLE && in_valid) begin
      opc_r <= in_opcode; ins_r <= in_instruction; pc_r <= in_pc; ld_r <= in_load_data;
    end
    if (state_r == S_DEC) begin
      a_r <= rf_rd(rs1, rf_a); b_r <= rf_rd(rs2, rf_b); tval_r <= rf_t;
    end
    res_r <= res_nxt;
    o_npc_r <= o_npc_nxt; o_mv_r <= o_mv_nxt; o_mw_r <= o_mw_nxt; o_addr_r <= o_addr_nxt;
    o_size_r <= o_size_nxt; o_wdata_r <= o_wdata_nxt; o_st_r <= o_st_nxt;
    o_tval_r <= o_tval_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_next_pc    = o_npc_r;
  assign out_mem_valid  = o_mv_r;
  assign out_mem_write  = o_mw_r;
  assign out_mem_addr   = o_addr_r;
  assign out_mem_size   = o_size_r;
  assign out_mem_wdata  = o_wdata_r;
  assign out_status     = o_st_r;
  assign out_trap_value = o_tval_r;
endmodule

[hdl/rv32_checker.sv]
// Port-level checker for the RV32IM executor, bound to the top level.
module rv32_checker import rv32_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_mem_valid,
  input logic [1:0]  out_status,
  input logic [31:0] out_trap_value
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid ##1 !out_valid) else $error("result too early");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");
  a_trap_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_NORMAL) |-> !out_mem_valid)
    else $error("trap with memory request");
  a_tval: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_EBREAK) |-> out_trap_value == 32'd0)
    else $error("stray trap value");
endmodule

bind rv32im_instruction_executor rv32_checker u_rv32_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_mem_valid(out_mem_valid),
  .out_status(out_status), .out_trap_value(out_trap_value)
);

[test/tb.sv]
// Self-checking testbench for the RV32IM instruction executor.
module tb;
  import rv32_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        mem_valid;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic [31:0] mem_wdata;
    logic [1:0]  status;
    logic [31:0] trap_value;
  } exec_result_t;

  typedef struct {
    logic         opcode;
    logic [31:0]  instruction;
    logic [31:0]  pc;
    logic [31:0]  load_data;
    logic         fixed;
    exec_result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_opcode;
  logic [31:0] in_instruction;
  logic [31:0] in_pc;
  logic [31:0] in_load_data;
  logic out_valid;
  logic out_ready;
  logic [31:0] out_next_pc;
  logic out_mem_valid;
  logic out_mem_write;
  logic [31:0] out_mem_addr;
  logic [1:0] out_mem_size;
  logic [31:0] out_mem_wdata;
  logic [1:0] out_status;
  logic [31:0] out_trap_value;

  rv32im_instruction_executor i_dut (.*);

  // predictor state
  logic [31:0] gpr [32];
  logic        load_parked;
  logic [4:0]  parked_rd;
  logic [1:0]  parked_size;
  logic        parked_signed;

  exec_result_t expected_q[$];
  bit failed;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] rd_gpr(input logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : gpr[idx];
  endfunction

  function automatic void wr_gpr(input logic [4:0] idx, input logic [31:0] v);
    if (idx != 5'd0) gpr[idx] = v;
  endfunction

  function automatic logic [31:0] width_mask(input logic [1:0] sz);
    case (sz)
      SZ_BYTE: return 32'hFF;
      SZ_HALF: return 32'hFFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] div_signed(input logic [31:0] a, input logic [31:0] b,
                                             input bit want_rem);
    if (b == 0) return want_rem ? a : 32'hFFFF_FFFF;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return want_rem ? 32'd0 : a;
    if (want_rem) return $signed(a) % $signed(b);
    return $signed(a) / $signed(b);
  endfunction

  // Execute one transaction on the predictor state and return its result.
  function automatic exec_result_t execute_item(input logic op, input logic [31:0] ins,
                                                input logic [31:0] pc, input logic [31:0] ld);
    exec_result_t r;
    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [4:0] rd;
    logic [31:0] a, b, immi, imms, immb, immj, v;
    logic signed [63:0] prod;
    bit taken;
    r = '0;
    opc = ins[6:0];
    f3 = ins[14:12];
    f7 = ins[31:25];
    rd = ins[11:7];
    a = rd_gpr(ins[19:15]);
    b = rd_gpr(ins[24:20]);
    immi = {{20{ins[31]}}, ins[31:20]};
    imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    if (op) begin
      if (load_parked) begin
        v = ld & width_mask(parked_size);
        if (parked_signed && parked_size == SZ_BYTE) v = {{24{v[7]}}, v[7:0]};
        if (parked_signed && parked_size == SZ_HALF) v = {{16{v[15]}}, v[15:0]};
        wr_gpr(parked_rd, v);
        load_parked = 1'b0;
      end
      return r;
    end
    r.next_pc = pc + 32'd4;
    if (opc == OP_LUI) begin
      wr_gpr(rd, {ins[31:12], 12'd0});
    end else if (opc == OP_AUIPC) begin
      wr_gpr(rd, pc + {ins[31:12], 12'd0});
    end else if (opc == OP_JAL) begin
      r.next_pc = pc + immj;
      wr_gpr(rd, pc + 32'd4);
    end else if (opc == OP_JALR && f3 == 3'd0) begin
      r.next_pc = (a + immi) & ~32'd1;
      wr_gpr(rd, pc + 32'd4);
    end else if (opc == OP_BRANCH && f3 != 3'd2 && f3 != 3'd3) begin
      case (f3)
        3'd0: taken = (a == b);
        3'd1: taken = (a != b);
        3'd4: taken = $signed(a) < $signed(b);
        3'd5: taken = $signed(a) >= $signed(b);
        3'd6: taken = a < b;
        default: taken = a >= b;
      endcase
      if (taken) r.next_pc = pc + immb;
    end else if (opc == OP_LOAD && f3 != 3'd3 && f3 < 3'd6) begin
      r.mem_valid = 1'b1;
      r.mem_addr = a + immi;
      r.mem_size = f3[1:0];
      load_parked = 1'b1;
      parked_rd = rd;
      parked_size = f3[1:0];
      parked_signed = (f3 < 3'd4);
    end else if (opc == OP_STORE && f3 < 3'd3) begin
      r.mem_valid = 1'b1;
      r.mem_write = 1'b1;
      r.mem_addr = a + imms;
      r.mem_size = f3[1:0];
      r.mem_wdata = b & width_mask(f3[1:0]);
    end else if (opc == OP_REG && f7 == 7'd0) begin
      case (f3)
        3'd0: v = a + b;
        3'd1: v = a << b[4:0];
        3'd2: v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        3'd3: v = (a < b) ? 32'd1 : 32'd0;
        3'd4: v = a ^ b;
        3'd5: v = a >> b[4:0];
        3'd6: v = a | b;
        default: v = a & b;
      endcase
      wr_gpr(rd, v);
    end else if (opc == OP_REG && f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)) begin
      wr_gpr(rd, (f3 == 3'd0) ? a - b : 32'($signed(a) >>> b[4:0]));
    end else if (opc == OP_REG && f7 == 7'd1 && f3 != 3'd2 && f3 != 3'd3) begin
      case (f3)
        3'd0: v = a * b;
        3'd1: begin
          prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          v = prod[63:32];
        end
        3'd4: v = div_signed(a, b, 1'b0);
        3'd5: v = (b == 0) ? 32'hFFFF_FFFF : a / b;
        3'd6: v = div_signed(a, b, 1'b1);
        default: v = (b == 0) ? a : a % b;
      endcase
      wr_gpr(rd, v);
    end else if (opc == OP_IMM && f3 != 3'd1 && f3 != 3'd5) begin
      case (f3)
        3'd0: v = a + immi;
        3'd2: v = ($signed(a) < $signed(immi)) ? 32'd1 : 32'd0;
        3'd3: v = (a < immi) ? 32'd1 : 32'd0;
        3'd4: v = a ^ immi;
        3'd6: v = a | immi;
        default: v = a & immi;
      endcase
      wr_gpr(rd, v);
    end else if (opc == OP_IMM && f3 == 3'd1 && f7 == 7'd0) begin
      wr_gpr(rd, a << ins[24:20]);
    end else if (opc == OP_IMM && f3 == 3'd5 && f7 == 7'd0) begin
      wr_gpr(rd, a >> ins[24:20]);
    end else if (opc == OP_IMM && f3 == 3'd5 && f7 == 7'h20) begin
      wr_gpr(rd, 32'($signed(a) >>> ins[24:20]));
    end else if (ins == WORD_EBREAK) begin
      r.status = ST_EBREAK;
      r.trap_value = rd_gpr(5'd10);
    end else begin
      r.status = ST_ILLEGAL;
    end
    return r;
  endfunction

  // Build a random instruction, mostly well formed, some noise.
  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    logic [6:0] f7;
    logic [2:0] f3;
    w = $urandom;
    f3 = w[14:12];
    f7 = 7'd0;
    case ($urandom_range(0, 15))
      0: w[6:0] = OP_LUI;
      1: w[6:0] = OP_AUIPC;
      2: w[6:0] = OP_JAL;
      3: begin w[6:0] = OP_JALR; if ($urandom_range(0, 7) != 0) w[14:12] = 3'd0; end
      4: w[6:0] = OP_BRANCH;
      5: w[6:0] = OP_LOAD;
      6: w[6:0] = OP_STORE;
      7, 8: begin
        case ($urandom_range(0, 4))
          0: f7 = 7'h20;
          1, 2: f7 = 7'd1;
          3: f7 = 7'd0;
          default: f7 = 7'($urandom);
        endcase
        w = {f7, w[24:15], f3, w[11:7], OP_REG};
      end
      9, 10, 11: begin
        w[6:0] = OP_IMM;
        if (f3 == 3'd1 || f3 == 3'd5) begin
          case ($urandom_range(0, 5))
            0, 1: w[31:25] = 7'd0;
            2, 3: w[31:25] = 7'h20;
            default: ;
          endcase
        end
      end
      12: w = WORD_EBREAK;
      13: w[6:0] = OP_IMM;
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_item(input logic op, input logic [31:0] ins, input logic [31:0] pc,
                           input logic [31:0] ld, input bit fixed, input exec_result_t want);
    exec_result_t got;
    got = execute_item(op, ins, pc, ld);
    if (fixed && got !== want) begin
      $display("%0t: directed row disagrees with predictor: expected %h actual %h",
               $time, want, got);
      failed = 1'b1;
    end
    expected_q.push_back(got);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_instruction <= ins;
    in_pc <= pc;
    in_load_data <= ld;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold valid low for a random gap between bursts.
  task automatic idle_gap();
    int n;
    n = $urandom_range(1, 6);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic stim_row_t row(input logic op, input logic [31:0] ins,
                                    input logic [31:0] pc, input logic [31:0] ld);
    stim_row_t s;
    s.opcode = op;
    s.instruction = ins;
    s.pc = pc;
    s.load_data = ld;
    s.fixed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic stim_row_t fixed_row(input logic [31:0] ins, input logic [31:0] pc,
                                          input logic [31:0] npc, input logic [1:0] st,
                                          input logic [31:0] tval);
    stim_row_t s;
    s = row(1'b0, ins, pc, 32'd0);
    s.fixed = 1'b1;
    s.want.next_pc = npc;
    s.want.status = st;
    s.want.trap_value = tval;
    return s;
  endfunction

  stim_row_t directed[$];

  initial begin
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = 1'b0;
    in_instruction = '0;
    in_pc = '0;
    in_load_data = '0;
    failed = 1'b0;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    load_parked = 1'b0;
    parked_rd = '0;
    parked_size = '0;
    parked_signed = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: ebreak sees a0 zero, two illegal words, load data with nothing parked
    directed.push_back(fixed_row(WORD_EBREAK, 32'hFFFF_FFFC, 32'd0, ST_EBREAK, 32'd0));
    directed.push_back(fixed_row(32'hFFFF_FFFF, 32'd0, 32'd4, ST_ILLEGAL, 32'd0));
    directed.push_back(fixed_row(32'd0, 32'h1000, 32'h1004, ST_ILLEGAL, 32'd0));
    directed.push_back(row(1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF));
    directed.push_back(row(1'b0, 32'h8000_0537, 32'd0, 32'd0));   // lui a0,0x80000
    directed.push_back(row(1'b0, 32'hFFF0_0593, 32'd0, 32'd0));   // addi a1,x0,-1
    directed.push_back(row(1'b0, 32'h02B5_4633, 32'd0, 32'd0));   // div a2,a0,a1 overflow
    directed.push_back(row(1'b0, 32'h02B5_66B3, 32'd0, 32'd0));   // rem a3,a0,a1 overflow
    directed.push_back(row(1'b0, 32'h0205_4733, 32'd0, 32'd0));   // div a4,a0,x0
    directed.push_back(row(1'b0, 32'h0205_77B3, 32'd0, 32'd0));   // remu a5,a0,x0
    directed.push_back(row(1'b0, 32'h02B5_1833, 32'd0, 32'd0));   // mulh a6,a0,a1
    directed.push_back(row(1'b0, 32'h02B5_2833, 32'd0, 32'd0));   // mulhsu: illegal
    directed.push_back(row(1'b0, 32'h4015_D893, 32'd0, 32'd0));   // srai a7,a1,1
    directed.push_back(row(1'b0, 32'h8015_D893, 32'd0, 32'd0));   // bad shamt field
    directed.push_back(row(1'b0, 32'h0005_1067, 32'd0, 32'd0));   // jalr, bad funct3
    directed.push_back(row(1'b0, 32'hFFF5_8067, 32'h10, 32'd0));  // jalr x0,-1(a1)
    directed.push_back(row(1'b0, 32'h8000_006F, 32'h0, 32'd0));   // jal min offset
    directed.push_back(row(1'b0, 32'hFEB5_CEE3, 32'h100, 32'd0)); // blt a1,a1
    directed.push_back(row(1'b0, 32'hFEA5_CEE3, 32'h100, 32'd0)); // blt a1,a0
    directed.push_back(row(1'b0, 32'hFFF5_C903, 32'd0, 32'd0));   // lbu s2,-1(a1)
    directed.push_back(row(1'b0, 32'hFFF5_9983, 32'd0, 32'd0));   // lh s3 replaces it
    directed.push_back(row(1'b1, 32'd0, 32'd0, 32'h1234_8765));
    directed.push_back(row(1'b0, 32'hFF35_AFA3, 32'd3, 32'd0));   // sw s3,-1(a1)
    directed.push_back(row(1'b0, 32'h0135_0023, 32'd3, 32'd0));   // sb s3,0(a0)
    directed.push_back(row(1'b0, WORD_EBREAK, 32'd8, 32'd0));

    foreach (directed[i])
      send_item(directed[i].opcode, directed[i].instruction, directed[i].pc,
                directed[i].load_data, directed[i].fixed, directed[i].want);

    burst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) != 0) idle_gap();
        burst = $urandom_range(1, 20);
      end
      burst--;
      if (load_parked && $urandom_range(0, 2) != 0)
        send_item(1'b1, $urandom, $urandom, $urandom, 1'b0, '0);
      else if ($urandom_range(0, 40) == 0)
        send_item(1'b1, $urandom, $urandom, $urandom, 1'b0, '0);
      else
        send_item(1'b0, random_instruction(), $urandom, $urandom, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Receiver stalls on its own pattern: quiet stretches and random stalls.
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        out_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
      end
    end
  end

  always @(posedge clk) begin
    exec_result_t got;
    exec_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_next_pc, out_mem_valid, out_mem_write, out_mem_addr, out_mem_size,
             out_mem_wdata, out_status, out_trap_value};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, got);
        failed = 1'b1;
      end else begin
        want = expected_q.pop_front();
        if (got.next_pc !== want.next_pc) begin
          $display("%0t: next_pc expected %h actual %h", $time, want.next_pc, got.next_pc);
          failed = 1'b1;
        end
        if (got.mem_valid !== want.mem_valid) begin
          $display("%0t: mem_valid expected %h actual %h", $time, want.mem_valid,
                   got.mem_valid);
          failed = 1'b1;
        end
        if (got.mem_write !== want.mem_write) begin
          $display("%0t: mem_write expected %h actual %h", $time, want.mem_write,
                   got.mem_write);
          failed = 1'b1;
        end
        if (got.mem_addr !== want.mem_addr) begin
          $display("%0t: mem_addr expected %h actual %h", $time, want.mem_addr, got.mem_addr);
          failed = 1'b1;
        end
        if (got.mem_size !== want.mem_size) begin
          $display("%0t: mem_size expected %h actual %h", $time, want.mem_size, got.mem_size);
          failed = 1'b1;
        end
        if (got.mem_wdata !== want.mem_wdata) begin
          $display("%0t: mem_wdata expected %h actual %h", $time, want.mem_wdata,
                   got.mem_wdata);
          failed = 1'b1;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %h actual %h", $time, want.status, got.status);
          failed = 1'b1;
        end
        if (got.trap_value !== want.trap_value) begin
          $display("%0t: trap_value expected %h actual %h", $time, want.trap_value,
                   got.trap_value);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
